// File: sv/atsd_pkg.sv
package atsd_pkg;

    localparam int AXIS_W     = 16;
    localparam int CAL_W      = 17;
    localparam int ANG_OUT_W  = 16;
    localparam int MAG_W      = 17;
    localparam int THR_W      = 17;
    localparam int TIME_W     = 16;
    localparam int SHIFT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int SQR_W      = 32;
    localparam int SYZ_W      = 33;
    localparam int SUM_W      = 34;
    localparam int SQ_IN_W    = 50;
    localparam int SQ_ROOT_W  = 25;
    localparam int CXY_W      = 30;
    localparam int ANG_W      = 26;
    localparam int ATAN_IDX_W = 5;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;

    localparam int ANG_LIMIT     = 23040;
    localparam int ANG_QUARTER   = 90 * 65536;
    localparam int ANG_ROUND     = 256;
    localparam int ANG_FRAC_BITS = 9;
    localparam int PRE_SHIFT     = 8;

    localparam logic [MAG_W-1:0]   MAG_RESET   = MAG_W'(16384);
    localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(11469);
    localparam logic [TIME_W-1:0]  HOLD_RESET  = TIME_W'(1200);
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X,
        CFG_OFFSET_Y,
        CFG_OFFSET_Z,
        CFG_SHAKE_ENABLE,
        CFG_SHAKE_THRESHOLD,
        CFG_HOLDOFF_MS,
        CFG_SMOOTH_SHIFT
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_Z,
        S_SQ_ACC,
        S_ROLL,
        S_ROLL_WAIT,
        S_PITCH,
        S_PITCH_WAIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_X,
        MUL_Y,
        MUL_Z
    } mul_sel_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] offset_x;
        logic signed [AXIS_W-1:0] offset_y;
        logic signed [AXIS_W-1:0] offset_z;
        logic                     shake_enable;
        logic [THR_W-1:0]         shake_threshold;
        logic [TIME_W-1:0]        holdoff_ms;
        logic [SHIFT_W-1:0]       smooth_shift;
    } cfg_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     root_start;
        logic     root_mag;
        logic     cordic_start;
        logic     cordic_pitch;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic root_busy;
        logic cordic_busy;
        logic out_free;
    } stat_t;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = ANG_W'(2949120);
            5'd1:    v = ANG_W'(1740967);
            5'd2:    v = ANG_W'(919879);
            5'd3:    v = ANG_W'(466945);
            5'd4:    v = ANG_W'(234379);
            5'd5:    v = ANG_W'(117304);
            5'd6:    v = ANG_W'(58666);
            5'd7:    v = ANG_W'(29335);
            5'd8:    v = ANG_W'(14668);
            5'd9:    v = ANG_W'(7334);
            5'd10:   v = ANG_W'(3667);
            5'd11:   v = ANG_W'(1833);
            5'd12:   v = ANG_W'(917);
            5'd13:   v = ANG_W'(458);
            5'd14:   v = ANG_W'(229);
            5'd15:   v = ANG_W'(115);
            5'd16:   v = ANG_W'(57);
            5'd17:   v = ANG_W'(29);
            5'd18:   v = ANG_W'(14);
            5'd19:   v = ANG_W'(7);
            5'd20:   v = ANG_W'(4);
            5'd21:   v = ANG_W'(2);
            5'd22:   v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/atsd_in_if.sv
interface atsd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [atsd_pkg::AXIS_W-1:0]  raw_x;
    logic signed [atsd_pkg::AXIS_W-1:0]  raw_y;
    logic signed [atsd_pkg::AXIS_W-1:0]  raw_z;
    logic [atsd_pkg::TIME_W-1:0]         elapsed_ms;

    modport source(output valid, raw_x, raw_y, raw_z, elapsed_ms, input ready);
    modport sink(input valid, raw_x, raw_y, raw_z, elapsed_ms, output ready);
endinterface

// File: sv/atsd_out_if.sv
interface atsd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [atsd_pkg::CAL_W-1:0]     cal_x;
    logic signed [atsd_pkg::CAL_W-1:0]     cal_y;
    logic signed [atsd_pkg::CAL_W-1:0]     cal_z;
    logic signed [atsd_pkg::ANG_OUT_W-1:0] roll_smoothed;
    logic signed [atsd_pkg::ANG_OUT_W-1:0] pitch_smoothed;
    logic                                  shake_detected;

    modport source(output valid, cal_x, cal_y, cal_z, roll_smoothed, pitch_smoothed,
                   shake_detected, input ready);
    modport sink(input valid, cal_x, cal_y, cal_z, roll_smoothed, pitch_smoothed,
                 shake_detected, output ready);
endinterface

// File: sv/atsd_cfg_if.sv
interface atsd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [atsd_pkg::CFG_IDX_W-1:0]      index;
    logic [atsd_pkg::CFG_DATA_W-1:0]     data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// File: sv/atsd_sqrt.sv
module atsd_sqrt (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [atsd_pkg::SQ_IN_W-1:0]       radicand,
    output logic                               busy,
    output logic [atsd_pkg::SQ_ROOT_W-1:0]     root,
    output logic                               round_up
);

    localparam int W = atsd_pkg::SQ_IN_W;
    localparam logic [W-1:0] BIT_TOP = {2'b01, {(W-2){1'b0}}};

    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] root_reg, root_next;
    logic [W-1:0] bit_reg, bit_next;
    logic [W-1:0] trial;

    always_comb
    begin
        trial     = root_reg + bit_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            rem_next  = radicand;
            root_next = '0;
            bit_next  = BIT_TOP;
        end
        else if (bit_reg != '0)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= '0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy     = (bit_reg != '0);
    assign root     = root_reg[atsd_pkg::SQ_ROOT_W-1:0];
    assign round_up = (rem_reg > root_reg);

endmodule

// File: sv/atsd_cordic.sv
module atsd_cordic #(
    parameter int STEPS = atsd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [atsd_pkg::CXY_W-1:0]      x_in,
    input  logic signed [atsd_pkg::CXY_W-1:0]      y_in,
    output logic                                   busy,
    output logic signed [atsd_pkg::ANG_OUT_W-1:0]  angle
);

    localparam int N     = (STEPS > atsd_pkg::CORDIC_STEPS_MAX) ?
                           atsd_pkg::CORDIC_STEPS_MAX : STEPS;
    localparam int CNT_W = $clog2(N + 1);
    localparam int XW    = atsd_pkg::CXY_W;
    localparam int AW    = atsd_pkg::ANG_W;

    logic signed [XW-1:0]  x_reg, x_next;
    logic signed [XW-1:0]  y_reg, y_next;
    logic signed [AW-1:0]  z_reg, z_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  zero_reg, zero_next;
    logic signed [XW-1:0]  dx, dy;
    logic signed [AW-1:0]  step_ang;
    logic signed [AW-1:0]  z_round, q;

    always_comb
    begin
        dx        = y_reg >>> cnt_reg;
        dy        = x_reg >>> cnt_reg;
        step_ang  = atsd_pkg::atan_entry(atsd_pkg::ATAN_IDX_W'(cnt_reg));
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        if (start)
        begin
            zero_next = (x_in == '0) && (y_in == '0);
            cnt_next  = '0;
            busy_next = 1'b1;
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_next = y_in;
                    y_next = -x_in;
                    z_next = AW'(atsd_pkg::ANG_QUARTER);
                end
                else
                begin
                    x_next = -y_in;
                    y_next = x_in;
                    z_next = -AW'(atsd_pkg::ANG_QUARTER);
                end
            end
            else
            begin
                x_next = x_in;
                y_next = y_in;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + step_ang;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - step_ang;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        z_round = z_reg + AW'(atsd_pkg::ANG_ROUND);
        q       = z_round >>> atsd_pkg::ANG_FRAC_BITS;
        if (zero_reg)
        begin
            angle = '0;
        end
        else if (q > AW'(atsd_pkg::ANG_LIMIT))
        begin
            angle = atsd_pkg::ANG_OUT_W'(atsd_pkg::ANG_LIMIT);
        end
        else if (q < -AW'(atsd_pkg::ANG_LIMIT))
        begin
            angle = -atsd_pkg::ANG_OUT_W'(atsd_pkg::ANG_LIMIT);
        end
        else
        begin
            angle = q[atsd_pkg::ANG_OUT_W-1:0];
        end
    end

    assign busy = busy_reg;

endmodule

// File: sv/atsd_datapath.sv
module atsd_datapath #(
    parameter int CORDIC_STEPS = atsd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  atsd_pkg::cmd_t                         cmd,
    input  atsd_pkg::cfg_t                         cfg,
    input  logic signed [atsd_pkg::AXIS_W-1:0]     raw_x,
    input  logic signed [atsd_pkg::AXIS_W-1:0]     raw_y,
    input  logic signed [atsd_pkg::AXIS_W-1:0]     raw_z,
    input  logic [atsd_pkg::TIME_W-1:0]            elapsed_ms,
    input  logic                                   out_ready,
    output atsd_pkg::stat_t                        stat,
    output logic                                   out_valid,
    output logic signed [atsd_pkg::CAL_W-1:0]      cal_x,
    output logic signed [atsd_pkg::CAL_W-1:0]      cal_y,
    output logic signed [atsd_pkg::CAL_W-1:0]      cal_z,
    output logic signed [atsd_pkg::ANG_OUT_W-1:0]  roll_smoothed,
    output logic signed [atsd_pkg::ANG_OUT_W-1:0]  pitch_smoothed,
    output logic                                   shake_detected
);

    localparam int CW = atsd_pkg::CAL_W;
    localparam int AO = atsd_pkg::ANG_OUT_W;
    localparam int XW = atsd_pkg::CXY_W;
    localparam int MW = atsd_pkg::MAG_W;
    localparam int TW = atsd_pkg::TIME_W;

    function automatic logic signed [AO-1:0] smooth(
        input logic signed [AO-1:0] f,
        input logic signed [AO-1:0] raw,
        input logic [atsd_pkg::SHIFT_W-1:0] sh
    );
        logic signed [AO+1:0] d, h, s;
        d = (AO+2)'(raw) - (AO+2)'(f);
        h = (sh == '0) ? '0 : ((AO+2)'(1) <<< (sh - 1'b1));
        s = (d + h) >>> sh;
        return AO'((AO+2)'(f) + s);
    endfunction

    logic signed [CW-1:0]            cx_reg, cy_reg, cz_reg;
    logic [TW-1:0]                   elapsed_reg;
    logic signed [CW-1:0]            mul_a;
    logic signed [2*CW-1:0]          mul_p;
    logic [atsd_pkg::SQR_W-1:0]      prod_reg;
    atsd_pkg::mul_sel_t              sel_reg;
    logic                            pv_reg;
    logic [atsd_pkg::SQR_W-1:0]      sxx_reg;
    logic [atsd_pkg::SYZ_W-1:0]      syz_reg;
    logic [atsd_pkg::SUM_W-1:0]      sq_sum;
    logic [atsd_pkg::SQ_IN_W-1:0]    radicand;
    logic                            root_busy, round_up;
    logic [atsd_pkg::SQ_ROOT_W-1:0]  root;
    logic signed [XW-1:0]            cx_in, cy_in;
    logic signed [XW-1:0]            ex, ey, ez;
    logic                            cordic_busy;
    logic signed [AO-1:0]            angle;
    logic signed [AO-1:0]            roll_reg;
    logic signed [AO-1:0]            roll_f_reg, roll_f_next;
    logic signed [AO-1:0]            pitch_f_reg, pitch_f_next;
    logic [MW-1:0]                   prev_mag_reg, prev_mag_next;
    logic [TW-1:0]                   tss_reg, tss_next;
    logic [MW-1:0]                   mag;
    logic [TW:0]                     tsum;
    logic [TW-1:0]                   tsat;
    logic signed [MW:0]              mdiff;
    logic [MW:0]                     delta;
    logic                            shake;
    logic                            out_valid_reg;
    logic signed [CW-1:0]            ox_reg, oy_reg, oz_reg;
    logic signed [AO-1:0]            oroll_reg, opitch_reg;
    logic                            oshake_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg      <= CW'(raw_x) - CW'(cfg.offset_x);
            cy_reg      <= CW'(raw_y) - CW'(cfg.offset_y);
            cz_reg      <= CW'(raw_z) - CW'(cfg.offset_z);
            elapsed_reg <= elapsed_ms;
        end
    end

    // squares through one shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            atsd_pkg::MUL_X: mul_a = cx_reg;
            atsd_pkg::MUL_Y: mul_a = cy_reg;
            atsd_pkg::MUL_Z: mul_a = cz_reg;
            default:         mul_a = cz_reg;
        endcase
        mul_p = mul_a * mul_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            sel_reg <= atsd_pkg::MUL_X;
        end
        else
        begin
            pv_reg  <= cmd.mul_en;
            sel_reg <= cmd.mul_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p[atsd_pkg::SQR_W-1:0];
        if (cmd.load)
        begin
            syz_reg <= '0;
        end
        else if (pv_reg)
        begin
            if (sel_reg == atsd_pkg::MUL_X)
            begin
                sxx_reg <= prod_reg;
            end
            else
            begin
                syz_reg <= syz_reg + atsd_pkg::SYZ_W'(prod_reg);
            end
        end
    end

    always_comb
    begin
        sq_sum = atsd_pkg::SUM_W'(syz_reg) + atsd_pkg::SUM_W'(sxx_reg);
        if (cmd.root_mag)
        begin
            radicand = atsd_pkg::SQ_IN_W'(sq_sum);
        end
        else
        begin
            radicand = atsd_pkg::SQ_IN_W'({syz_reg, 16'h0000});
        end
    end

    atsd_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.root_start),
        .radicand (radicand),
        .busy     (root_busy),
        .root     (root),
        .round_up (round_up)
    );

    always_comb
    begin
        ex = XW'(cx_reg);
        ey = XW'(cy_reg);
        ez = XW'(cz_reg);
        if (cmd.cordic_pitch)
        begin
            cx_in = XW'(root);
            cy_in = (-ex) <<< atsd_pkg::PRE_SHIFT;
        end
        else
        begin
            cx_in = ez <<< atsd_pkg::PRE_SHIFT;
            cy_in = ey <<< atsd_pkg::PRE_SHIFT;
        end
    end

    atsd_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cordic_start),
        .x_in  (cx_in),
        .y_in  (cy_in),
        .busy  (cordic_busy),
        .angle (angle)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cordic_start && cmd.cordic_pitch)
        begin
            roll_reg <= angle;
        end
    end

    always_comb
    begin
        mag   = MW'(root) + MW'(round_up);
        tsum  = (TW+1)'(tss_reg) + (TW+1)'(elapsed_reg);
        tsat  = tsum[TW] ? {TW{1'b1}} : tsum[TW-1:0];
        mdiff = $signed({1'b0, mag}) - $signed({1'b0, prev_mag_reg});
        delta = (mdiff < 0) ? (MW+1)'(-mdiff) : (MW+1)'(mdiff);
        shake = cfg.shake_enable && (delta > (MW+1)'(cfg.shake_threshold))
                && (tsat > cfg.holdoff_ms);

        roll_f_next   = roll_f_reg;
        pitch_f_next  = pitch_f_reg;
        prev_mag_next = prev_mag_reg;
        tss_next      = tss_reg;
        if (cmd.finish)
        begin
            roll_f_next  = smooth(roll_f_reg, roll_reg, cfg.smooth_shift);
            pitch_f_next = smooth(pitch_f_reg, angle, cfg.smooth_shift);
            tss_next     = shake ? '0 : tsat;
            if (cfg.shake_enable)
            begin
                prev_mag_next = mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_f_reg    <= '0;
            pitch_f_reg   <= '0;
            prev_mag_reg  <= atsd_pkg::MAG_RESET;
            tss_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            roll_f_reg   <= roll_f_next;
            pitch_f_reg  <= pitch_f_next;
            prev_mag_reg <= prev_mag_next;
            tss_reg      <= tss_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            ox_reg     <= cx_reg;
            oy_reg     <= cy_reg;
            oz_reg     <= cz_reg;
            oroll_reg  <= roll_f_next;
            opitch_reg <= pitch_f_next;
            oshake_reg <= shake;
        end
    end

    assign stat.root_busy   = root_busy;
    assign stat.cordic_busy = cordic_busy;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign cal_x          = ox_reg;
    assign cal_y          = oy_reg;
    assign cal_z          = oz_reg;
    assign roll_smoothed  = oroll_reg;
    assign pitch_smoothed = opitch_reg;
    assign shake_detected = oshake_reg;

endmodule

// File: sv/atsd_ctrl.sv
module atsd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  atsd_pkg::stat_t  stat,
    output logic             in_ready,
    output atsd_pkg::cmd_t   cmd
);

    atsd_pkg::state_t state_reg, state_next;
    logic             units_idle;

    assign units_idle = !stat.root_busy && !stat.cordic_busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            atsd_pkg::S_IDLE:       if (in_valid) state_next = atsd_pkg::S_SQ_X;
            atsd_pkg::S_SQ_X:       state_next = atsd_pkg::S_SQ_Y;
            atsd_pkg::S_SQ_Y:       state_next = atsd_pkg::S_SQ_Z;
            atsd_pkg::S_SQ_Z:       state_next = atsd_pkg::S_SQ_ACC;
            atsd_pkg::S_SQ_ACC:     state_next = atsd_pkg::S_ROLL;
            atsd_pkg::S_ROLL:       state_next = atsd_pkg::S_ROLL_WAIT;
            atsd_pkg::S_ROLL_WAIT:  if (units_idle) state_next = atsd_pkg::S_PITCH;
            atsd_pkg::S_PITCH:      state_next = atsd_pkg::S_PITCH_WAIT;
            atsd_pkg::S_PITCH_WAIT: if (units_idle) state_next = atsd_pkg::S_DONE;
            atsd_pkg::S_DONE:       if (stat.out_free) state_next = atsd_pkg::S_IDLE;
            default:                state_next = atsd_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            atsd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            atsd_pkg::S_SQ_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = atsd_pkg::MUL_X;
            end
            atsd_pkg::S_SQ_Y:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = atsd_pkg::MUL_Y;
            end
            atsd_pkg::S_SQ_Z:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = atsd_pkg::MUL_Z;
            end
            atsd_pkg::S_ROLL:
            begin
                cmd.root_start   = 1'b1;
                cmd.cordic_start = 1'b1;
            end
            atsd_pkg::S_PITCH:
            begin
                cmd.root_start   = 1'b1;
                cmd.root_mag     = 1'b1;
                cmd.cordic_start = 1'b1;
                cmd.cordic_pitch = 1'b1;
            end
            atsd_pkg::S_DONE:
            begin
                cmd.root_mag = 1'b1;
                cmd.finish   = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= atsd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/accel_tilt_and_shake_detector.sv
// channel   dir  handshake     payload
// in_ch     in   valid/ready   raw_x, raw_y, raw_z, elapsed_ms
// out_ch    out  valid/ready   cal_x, cal_y, cal_z, roll_smoothed, pitch_smoothed,
//                              shake_detected
// cfg_ch    in   valid/ready   index, data (always ready)
//
// one item at a time; the shared bit-per-cycle square root unit runs twice per
// item (roll cordic overlaps the first pass, pitch cordic the second)
// asynchronous active-low reset clears filters and timer, presets the previous
// magnitude to MAG_RESET and resets control
// the result waits in an output register; a stalled output holds the next
// item only at its last step

module accel_tilt_and_shake_detector #(
    parameter int CORDIC_STEPS = atsd_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    atsd_in_if.sink      in_ch,
    atsd_out_if.source   out_ch,
    atsd_cfg_if.sink     cfg_ch
);

    atsd_pkg::cfg_t  cfg_reg;
    atsd_pkg::cmd_t  cmd;
    atsd_pkg::stat_t stat;
    logic            cfg_we;

    assign cfg_ch.ready = 1'b1;
    assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x        <= '0;
            cfg_reg.offset_y        <= '0;
            cfg_reg.offset_z        <= '0;
            cfg_reg.shake_enable    <= 1'b1;
            cfg_reg.shake_threshold <= atsd_pkg::THR_RESET;
            cfg_reg.holdoff_ms      <= atsd_pkg::HOLD_RESET;
            cfg_reg.smooth_shift    <= atsd_pkg::SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (atsd_pkg::cfg_idx_t'(cfg_ch.index))
                atsd_pkg::CFG_OFFSET_X:
                    cfg_reg.offset_x <= cfg_ch.data[atsd_pkg::AXIS_W-1:0];
                atsd_pkg::CFG_OFFSET_Y:
                    cfg_reg.offset_y <= cfg_ch.data[atsd_pkg::AXIS_W-1:0];
                atsd_pkg::CFG_OFFSET_Z:
                    cfg_reg.offset_z <= cfg_ch.data[atsd_pkg::AXIS_W-1:0];
                atsd_pkg::CFG_SHAKE_ENABLE:
                    cfg_reg.shake_enable <= cfg_ch.data[0];
                atsd_pkg::CFG_SHAKE_THRESHOLD:
                    cfg_reg.shake_threshold <= cfg_ch.data[atsd_pkg::THR_W-1:0];
                atsd_pkg::CFG_HOLDOFF_MS:
                    cfg_reg.holdoff_ms <= cfg_ch.data[atsd_pkg::TIME_W-1:0];
                atsd_pkg::CFG_SMOOTH_SHIFT:
                    cfg_reg.smooth_shift <= cfg_ch.data[atsd_pkg::SHIFT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    atsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .stat     (stat),
        .in_ready (in_ch.ready),
        .cmd      (cmd)
    );

    atsd_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg            (cfg_reg),
        .raw_x          (in_ch.raw_x),
        .raw_y          (in_ch.raw_y),
        .raw_z          (in_ch.raw_z),
        .elapsed_ms     (in_ch.elapsed_ms),
        .out_ready      (out_ch.ready),
        .stat           (stat),
        .out_valid      (out_ch.valid),
        .cal_x          (out_ch.cal_x),
        .cal_y          (out_ch.cal_y),
        .cal_z          (out_ch.cal_z),
        .roll_smoothed  (out_ch.roll_smoothed),
        .pitch_smoothed (out_ch.pitch_smoothed),
        .shake_detected (out_ch.shake_detected)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("item accepted while busy");

    a_shake_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) && out_ch.shake_detected |-> cfg_reg.shake_enable)
        else $error("shake flagged with detection disabled");

    a_shift_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_ch.index == atsd_pkg::CFG_SMOOTH_SHIFT
        |=> cfg_reg.smooth_shift == $past(cfg_ch.data[atsd_pkg::SHIFT_W-1:0]))
        else $error("smooth shift write lost");

endmodule
